@@ hw/rtl/utf8_validator_with_escape_check_top_defines.svh @@
// Assertion macros for the UTF-8 validator.
`ifndef UTF8_VALIDATOR_WITH_ESCAPE_CHECK_TOP_DEFINES_SVH
`define UTF8_VALIDATOR_WITH_ESCAPE_CHECK_TOP_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define UTF8V_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("utf8v check failed");

// Condition must hold in the cycle after the trigger.
`define UTF8V_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("utf8v check failed");

`endif

@@ hw/rtl/utf8v_pkg.sv @@
// Shared types, constants and the byte decode function of the UTF-8 validator.
`default_nettype none
package utf8v_pkg;

  localparam logic [7:0] MASK_CONT   = 8'hc0;
  localparam logic [7:0] CONT_CODE   = 8'h80;
  localparam logic [7:0] MASK_LEAD3  = 8'he0;
  localparam logic [7:0] MASK_LEAD4  = 8'hf0;
  localparam logic [7:0] MASK_LEAD5  = 8'hf8;
  localparam logic [7:0] MASK_OVR2   = 8'hfe;
  localparam logic [7:0] LEAD2_CODE  = 8'hc0;
  localparam logic [7:0] LEAD3_CODE  = 8'he0;
  localparam logic [7:0] LEAD4_CODE  = 8'hf0;
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] CTRL_LIMIT  = 8'h1f;
  localparam logic [7:0] QUOTE_CHAR  = 8'h22;
  localparam logic [7:0] BSLASH_CHAR = 8'h5c;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;
  localparam logic [1:0] PEND_THREE = 2'd3;

  typedef struct packed {
    logic [1:0] bytes_pending;
    logic       after_e0_lead;
    logic       after_f0_lead;
    logic       error_seen;
    logic       escape_seen;
  } dec_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic valid_utf8;
    logic plain_json;
  } result_t;

  function automatic dec_state_t flag_error(dec_state_t s);
    dec_state_t r;
    r = s;
    r.error_seen    = 1'b1;
    r.bytes_pending = PEND_NONE;
    r.after_e0_lead = 1'b0;
    r.after_f0_lead = 1'b0;
    return r;
  endfunction

  function automatic dec_state_t take_byte(dec_state_t s, logic [7:0] c);
    dec_state_t r;
    r = s;
    if (s.bytes_pending != PEND_NONE) begin
      if ((c & MASK_CONT) != CONT_CODE) begin
        r = flag_error(s);
      end else if (s.after_e0_lead && ((c & MASK_LEAD3) == CONT_CODE)) begin
        r = flag_error(s);
      end else if (s.after_f0_lead && ((c & MASK_LEAD4) == CONT_CODE)) begin
        r = flag_error(s);
      end else begin
        r.after_e0_lead = 1'b0;
        r.after_f0_lead = 1'b0;
        r.bytes_pending = s.bytes_pending - PEND_ONE;
      end
    end else if (c < ASCII_LIMIT) begin
      if (c inside {[8'h00:CTRL_LIMIT], QUOTE_CHAR, BSLASH_CHAR}) begin
        r.escape_seen = 1'b1;
      end
    end else if ((c & MASK_LEAD3) == LEAD2_CODE) begin
      if ((c & MASK_OVR2) == LEAD2_CODE) begin
        r = flag_error(s);
      end else begin
        r.bytes_pending = PEND_ONE;
      end
    end else if ((c & MASK_LEAD4) == LEAD3_CODE) begin
      r.after_e0_lead = (c == LEAD3_CODE);
      r.bytes_pending = PEND_TWO;
    end else if ((c & MASK_LEAD5) == LEAD4_CODE) begin
      r.after_f0_lead = (c == LEAD4_CODE);
      r.bytes_pending = PEND_THREE;
    end else begin
      r = flag_error(s);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/utf8v_ifs.sv @@
// Valid/ready channel interfaces for name bytes and results.
`default_nettype none
interface utf8v_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface utf8v_result_if;
  logic valid;
  logic ready;
  logic valid_utf8;
  logic plain_json;

  modport source (output valid, output valid_utf8, output plain_json, input ready);
  modport sink   (input valid, input valid_utf8, input plain_json, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/utf8v_in_stage.sv @@
// Input register: captures one byte transaction and holds it until consumed.
`default_nettype none
module utf8v_in_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  utf8v_byte_if.sink            byte_ch,
  input  wire logic             take,
  output utf8v_pkg::in_item_t   item
);
  import utf8v_pkg::*;

  logic       valid;
  logic [7:0] byte_q;
  logic       last_q;

  assign byte_ch.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (byte_ch.valid && byte_ch.ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      byte_q <= byte_ch.byte_in;
      last_q <= byte_ch.last_byte;
    end
  end

  assign item = '{valid: valid, byte_in: byte_q, last_byte: last_q};
endmodule
`default_nettype wire

@@ hw/rtl/utf8v_decode.sv @@
// Sequence state register and per-byte decode; forms the result on the final byte.
`default_nettype none
module utf8v_decode (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  utf8v_pkg::in_item_t     item,
  output utf8v_pkg::result_t      result,
  output utf8v_pkg::dec_state_t   state
);
  import utf8v_pkg::*;

  dec_state_t state_next;
  logic       ok;

  assign state_next = take_byte(state, item.byte_in);
  assign ok = !state_next.error_seen && (state_next.bytes_pending == PEND_NONE);
  assign result = '{valid_utf8: ok, plain_json: ok && !state_next.escape_seen};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      // clear everything at the end of a name
      state <= item.last_byte ? dec_state_t'('0) : state_next;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/utf8v_out_stage.sv @@
// Result register: holds one result transaction until the sink takes it.
`default_nettype none
module utf8v_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  utf8v_pkg::result_t    result,
  output logic                  free,
  utf8v_result_if.source        result_ch
);
  import utf8v_pkg::*;

  logic    valid;
  result_t held;

  assign free = !valid || result_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign result_ch.valid      = valid;
  assign result_ch.valid_utf8 = held.valid_utf8;
  assign result_ch.plain_json = held.plain_json;
endmodule
`default_nettype wire

@@ hw/rtl/utf8_validator_with_escape_check_top.sv @@
// Top level of the UTF-8 validator with JSON escape check.
`default_nettype none
`include "utf8_validator_with_escape_check_top_defines.svh"
// Takes a name one byte per transaction on byte_ch, last_byte set on the final byte,
// and returns one transaction on result_ch per name: valid_utf8 (well-formed UTF-8,
// with surrogates and leads F5-F7 allowed) and plain_json (valid and free of control
// bytes, quote and backslash). Throughput is one byte per clock unless the result
// side stalls a final byte; the single loop is the sequence state register updated
// by a few gates of decode. A result passes input register, then result register.
// byte_ch.ready depends combinationally on result_ch.ready only while a final byte
// waits on a full result register; non-final bytes never wait on the result side.
module utf8_validator_with_escape_check_top (
  input  wire logic      clk,
  input  wire logic      rst,
  utf8v_byte_if.sink     byte_ch,
  utf8v_result_if.source result_ch
);
  import utf8v_pkg::*;

  in_item_t   item;
  result_t    result;
  dec_state_t state;
  logic       take;
  logic       out_free;

  // advance a byte unless it is final and the result slot is busy
  assign take = item.valid && (!item.last_byte || out_free);

  utf8v_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .take    (take),
    .item    (item)
  );

  utf8v_decode u_dec (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (item),
    .result (result),
    .state  (state)
  );

  utf8v_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && item.last_byte),
    .result    (result),
    .free      (out_free),
    .result_ch (result_ch)
  );

  `UTF8V_ASSERT_SAME(a_plain_implies_valid, result_ch.valid, !result_ch.plain_json || result_ch.valid_utf8)
  `UTF8V_ASSERT_NEXT(a_state_clears_at_end, take && item.last_byte, state == dec_state_t'('0))
  `UTF8V_ASSERT_NEXT(a_final_gives_result, take && item.last_byte, result_ch.valid)

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the UTF-8 validator with JSON escape check.
`default_nettype none
module tb;

  localparam logic [7:0] CTRL_TOP       = 8'h1f;
  localparam logic [7:0] QUOTE_BYTE     = 8'h22;
  localparam logic [7:0] BACKSLASH_BYTE = 8'h5c;
  localparam logic [7:0] E0_LEAD        = 8'he0;
  localparam logic [7:0] F0_LEAD        = 8'hf0;

  localparam int RANDOM_BYTES  = 1000;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 15;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic valid_utf8;
    logic plain_json;
  } verdict_t;

  // Predicts the verdict of each name and holds verdicts not yet returned.
  class verdict_board;
    logic [1:0] cont_left;
    bit         need_a0;
    bit         need_90;
    bit         bad_seen;
    bit         esc_seen;
    verdict_t   pending_verdicts[$];
    int         failures;

    function new();
      clear_name();
      failures = 0;
    endfunction

    function void clear_name();
      cont_left = 2'd0;
      need_a0   = 1'b0;
      need_90   = 1'b0;
      bad_seen  = 1'b0;
      esc_seen  = 1'b0;
    endfunction

    // Latch the error and restart decoding at the next byte.
    function void mark_bad();
      bad_seen  = 1'b1;
      cont_left = 2'd0;
      need_a0   = 1'b0;
      need_90   = 1'b0;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      verdict_t v;
      if (cont_left != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          mark_bad();
        end else if (need_a0 && !b[5]) begin
          mark_bad();
        end else if (need_90 && b[5:4] == 2'b00) begin
          mark_bad();
        end else begin
          need_a0   = 1'b0;
          need_90   = 1'b0;
          cont_left = cont_left - 2'd1;
        end
      end else if (!b[7]) begin
        if (b <= CTRL_TOP || b == QUOTE_BYTE || b == BACKSLASH_BYTE) esc_seen = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        // C0 and C1 can only encode overlong ASCII
        if (b[4:1] == 4'd0) mark_bad();
        else cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        need_a0   = (b == E0_LEAD);
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        need_90   = (b == F0_LEAD);
        cont_left = 2'd3;
      end else begin
        mark_bad();
      end
      if (last) begin
        v.valid_utf8 = !bad_seen && cont_left == 2'd0;
        v.plain_json = v.valid_utf8 && !esc_seen;
        pending_verdicts.push_back(v);
        clear_name();
      end
    endfunction

    function void check_verdict(logic valid_utf8, logic plain_json);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result transaction: valid_utf8=%0b plain_json=%0b",
               valid_utf8, plain_json);
        failures++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (valid_utf8 !== want.valid_utf8) begin
        $error("valid_utf8: expected %0b, actual %0b", want.valid_utf8, valid_utf8);
        failures++;
      end
      if (plain_json !== want.plain_json) begin
        $error("plain_json: expected %0b, actual %0b", want.plain_json, plain_json);
        failures++;
      end
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  utf8v_byte_if   byte_ch();
  utf8v_result_if result_ch();

  utf8_validator_with_escape_check_top dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  always #2 clk = ~clk;

  verdict_board board = new();
  logic [7:0]   name_buf[$];
  int           burst_left   = 0;
  int           sent_bytes   = 0;
  int           results_seen = 0;
  int           cycle_count  = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      board.check_verdict(result_ch.valid_utf8, result_ch.plain_json);
      results_seen++;
    end
  end

  // Receiver: stall pattern is redrawn at random among four modes; one long hold-off early on.
  initial begin
    int  cyc;
    int  mode;
    bit  held;
    cyc  = 0;
    mode = 0;
    held = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        @(negedge clk);
      end
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= $urandom_range(0, 1);
        2:       result_ch.ready <= ($urandom_range(0, 7) != 0);
        default: result_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Drop valid and drive junk on the payload for the whole idle gap.
  task automatic idle_gap(input int n);
    byte_ch.valid     <= 1'b0;
    byte_ch.byte_in   <= $urandom_range(0, 255);
    byte_ch.last_byte <= $urandom_range(0, 1);
    repeat (n) @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 12);
      idle_gap($urandom_range(1, ($urandom_range(0, 7) == 0) ? 25 : 4));
    end
    burst_left--;
    byte_ch.valid     <= 1'b1;
    byte_ch.byte_in   <= b;
    byte_ch.last_byte <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    board.note_byte(b, last);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_name();
    foreach (name_buf[i]) send_byte(name_buf[i], i == name_buf.size() - 1);
  endtask

  task automatic wait_drained();
    idle_gap(1);
    burst_left = 0;
    while (board.outstanding() != 0) @(negedge clk);
  endtask

  task automatic push_cont();
    name_buf.push_back(8'(($urandom_range(0, 63)) | 8'h80));
  endtask

  // Mostly well-formed names of 1 to 6 characters, some of them broken.
  task automatic random_name();
    int pos;
    name_buf.delete();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
              0:       name_buf.push_back(8'($urandom_range(0, CTRL_TOP)));
              1:       name_buf.push_back(QUOTE_BYTE);
              default: name_buf.push_back(BACKSLASH_BYTE);
            endcase
          end else begin
            name_buf.push_back(8'($urandom_range(8'h20, 8'h7f)));
          end
        end
        4, 5: begin
          name_buf.push_back(8'($urandom_range(8'hc2, 8'hdf)));
          push_cont();
        end
        6, 7: begin
          case ($urandom_range(0, 2))
            0: begin
              name_buf.push_back(E0_LEAD);
              name_buf.push_back(8'($urandom_range(8'ha0, 8'hbf)));
            end
            1: begin
              name_buf.push_back(8'hed);
              push_cont();
            end
            default: begin
              name_buf.push_back(8'($urandom_range(8'he1, 8'hef)));
              push_cont();
            end
          endcase
          push_cont();
        end
        8: begin
          if ($urandom_range(0, 1) == 0) begin
            name_buf.push_back(F0_LEAD);
            name_buf.push_back(8'($urandom_range(8'h90, 8'hbf)));
          end else begin
            name_buf.push_back(8'($urandom_range(8'hf1, 8'hf7)));
            push_cont();
          end
          push_cont();
          push_cont();
        end
        default: name_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 6) == 0) begin
      pos = $urandom_range(0, name_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: name_buf[pos] = 8'($urandom_range(0, 255));
        1: if (name_buf.size() > 1) void'(name_buf.pop_back());
        default: begin
          if ($urandom_range(0, 1) == 0) name_buf.insert(pos, 8'($urandom_range(8'hc0, 8'hc1)));
          else name_buf.insert(pos, 8'($urandom_range(8'hf8, 8'hff)));
        end
      endcase
    end
  endtask

  initial begin
    int names_sent;
    byte_ch.valid     <= 1'b0;
    byte_ch.byte_in   <= 8'h00;
    byte_ch.last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    name_buf = '{8'h00};                 send_name();
    name_buf = '{8'h7f, 8'h20};          send_name();
    name_buf = '{QUOTE_BYTE};            send_name();
    name_buf = '{BACKSLASH_BYTE, 8'h1f}; send_name();
    name_buf = '{8'hc2, 8'h80};          send_name();
    name_buf = '{8'hc1, 8'h80};          send_name();
    name_buf = '{E0_LEAD, 8'h9f, 8'hbf}; send_name();
    name_buf = '{E0_LEAD, 8'ha0, 8'h80}; send_name();
    name_buf = '{F0_LEAD, 8'h8f};        send_name();
    name_buf = '{8'hf7, 8'hbf, 8'hbf, 8'hbf}; send_name();
    name_buf = '{8'hff};                 send_name();
    // surrogate lead cut short at the final byte
    name_buf = '{8'hed, 8'ha0};          send_name();
    wait_drained();

    names_sent = 0;
    while (sent_bytes < RANDOM_BYTES + 25) begin
      random_name();
      send_name();
      names_sent++;
      if (names_sent == 60) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/utf8v_pkg.sv
hw/rtl/utf8v_ifs.sv
hw/rtl/utf8v_in_stage.sv
hw/rtl/utf8v_decode.sv
hw/rtl/utf8v_out_stage.sv
hw/rtl/utf8_validator_with_escape_check_top.sv
tb/tb.sv
